// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/dcmf_pkg.sv -----
// ---------------------------------------------------------------------------
// dcmf_pkg
// Types and constants shared by the dual CPU mailbox FIFO modules
// ---------------------------------------------------------------------------
package dcmf_pkg;

    // access word and register port widths
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned PADDR_W = 5;
    localparam int unsigned PDATA_W = 32;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned M_TDATA_W = 40;

    // access codes carried in s_tuser
    typedef enum logic [OP_W-1:0] {
        OP_A_SEND = 2'd0,
        OP_A_RECV = 2'd1,
        OP_B_SEND = 2'd2,
        OP_B_RECV = 2'd3
    } opcode_t;

    // register index, byte address is four times the index
    typedef enum logic [2:0] {
        REG_A_FIFO_EN      = 3'd0,
        REG_B_FIFO_EN      = 3'd1,
        REG_A_RECV_IRQ_EN  = 3'd2,
        REG_B_RECV_IRQ_EN  = 3'd3,
        REG_A_SEND_IRQ_EN  = 3'd4,
        REG_B_SEND_IRQ_EN  = 3'd5
    } reg_idx_t;

    // configuration bits as seen by the datapath
    typedef struct packed {
        logic a_fifo_en;
        logic b_fifo_en;
        logic a_recv_irq_en;
        logic b_recv_irq_en;
        logic a_send_irq_en;
        logic b_send_irq_en;
    } cfg_t;

    // fill status of one queue
    typedef struct packed {
        logic full;
        logic empty;
        logic single;
    } qstat_t;

endpackage

// ----- src/dcmf_ram.sv -----
// ---------------------------------------------------------------------------
// dcmf_ram
// Simple dual port RAM, one write port, one read port with registered data
// ---------------------------------------------------------------------------
module dcmf_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/dcmf_queue.sv -----
// ---------------------------------------------------------------------------
// dcmf_queue
// One mailbox queue: read and write pointers, fill count and word storage
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dcmf_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  logic [dcmf_pkg::WORD_W-1:0] wdata,
    input  logic                   pop,
    output logic [dcmf_pkg::WORD_W-1:0] rdata,
    output dcmf_pkg::qstat_t       status
);

    import dcmf_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // fill status from the count
    assign status.full   = (cnt_reg == CNT_W'(DEPTH));
    assign status.empty  = (cnt_reg == '0);
    assign status.single = (cnt_reg == CNT_W'(1));

    // pointer and count update, pointers wrap at the last slot
    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            cnt_next    = cnt_reg + 1'b1;
        end else if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            cnt_next    = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // word storage
    dcmf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (push),
        .waddr (wr_ptr_reg),
        .wdata (wdata),
        .re    (pop),
        .raddr (rd_ptr_reg),
        .rdata (rdata)
    );

    // checks
    `ASSERT_ALWAYS(a_cnt_in_range, cnt_reg <= CNT_W'(DEPTH), "queue count above depth")
    `ASSERT_ALWAYS(a_push_guarded, !(push && status.full) && !(pop && status.empty),
        "push into full or pop from empty queue")

endmodule

// ----- src/dcmf_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// dcmf_cfg_regs
// Register port for the enable and interrupt enable bits
// ---------------------------------------------------------------------------
module dcmf_cfg_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dcmf_pkg::PADDR_W-1:0] paddr,
    input  logic [dcmf_pkg::PDATA_W-1:0] pwdata,
    output logic [dcmf_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output dcmf_pkg::cfg_t               cfg
);

    import dcmf_pkg::*;

    cfg_t     cfg_reg;
    logic     wr_en;
    logic     rd_bit;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

    // register writes, only bit 0 is kept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_A_FIFO_EN:     cfg_reg.a_fifo_en     <= pwdata[0];
                REG_B_FIFO_EN:     cfg_reg.b_fifo_en     <= pwdata[0];
                REG_A_RECV_IRQ_EN: cfg_reg.a_recv_irq_en <= pwdata[0];
                REG_B_RECV_IRQ_EN: cfg_reg.b_recv_irq_en <= pwdata[0];
                REG_A_SEND_IRQ_EN: cfg_reg.a_send_irq_en <= pwdata[0];
                REG_B_SEND_IRQ_EN: cfg_reg.b_send_irq_en <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (idx)
            REG_A_FIFO_EN:     rd_bit = cfg_reg.a_fifo_en;
            REG_B_FIFO_EN:     rd_bit = cfg_reg.b_fifo_en;
            REG_A_RECV_IRQ_EN: rd_bit = cfg_reg.a_recv_irq_en;
            REG_B_RECV_IRQ_EN: rd_bit = cfg_reg.b_recv_irq_en;
            REG_A_SEND_IRQ_EN: rd_bit = cfg_reg.a_send_irq_en;
            REG_B_SEND_IRQ_EN: rd_bit = cfg_reg.b_send_irq_en;
            default:           rd_bit = 1'b0;
        endcase
    end

    assign prdata = {{(PDATA_W-1){1'b0}}, rd_bit};
    assign cfg    = cfg_reg;

endmodule

// ----- src/dual_cpu_mailbox_fifo.sv -----
// Pipeline: an accepted request is held in the stage one register, then moves on to the
// result register, which drives m_tvalid, once that register is free.
// Throughput: one request per cycle while m_tready keeps the result register free; the
// registered read of the queue RAM forms the first stage and the result register the second.
// Reset: synchronous, active low; clears pointers, counts, error flags, configuration
// and pipeline valids; queue storage is not cleared.
// ---------------------------------------------------------------------------
// dual_cpu_mailbox_fifo
// Mailbox queue pair between CPU A and CPU B with error flags and interrupt pulses
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dual_cpu_mailbox_fifo #(
    parameter int unsigned FIFO_DEPTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dcmf_pkg::WORD_W-1:0]    s_tdata,  // [31:0] write_data
    input  logic [dcmf_pkg::OP_W-1:0]      s_tuser,  // [1:0] opcode
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] read_data, [32] side_a_error, [33] side_b_error, [34] irq_a_recv_fifo,
    // [35] irq_a_send_fifo, [36] irq_b_recv_fifo, [37] irq_b_send_fifo, [39:38] zero
    output logic [dcmf_pkg::M_TDATA_W-1:0] m_tdata,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dcmf_pkg::PADDR_W-1:0]   paddr,
    input  logic [dcmf_pkg::PDATA_W-1:0]   pwdata,
    output logic [dcmf_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    import dcmf_pkg::*;

    // control carried alongside the RAM read
    typedef struct packed {
        logic pop_ok;
        logic pop_ab;
        logic err_a;
        logic err_b;
        logic irq_a_recv;
        logic irq_a_send;
        logic irq_b_recv;
        logic irq_b_send;
    } stage_t;

    cfg_t    cfg;
    qstat_t  ab_st, ba_st;
    logic [WORD_W-1:0] ab_rdata, ba_rdata, rd_word;
    opcode_t op;
    logic    accept, side_b, is_recv, side_en, stage_adv;
    logic    push_ab, push_ba, pop_ab, pop_ba, set_err_a, set_err_b;
    logic    err_a_reg, err_b_reg, err_a_next, err_b_next;
    logic    p1_valid_reg, m_valid_reg;
    stage_t  p1_reg, p1_next;
    logic [M_TDATA_W-1:0] m_data_reg;

    // register port
    dcmf_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake: stage one moves on when the result register is free
    assign stage_adv = !m_valid_reg || m_tready;
    assign s_tready  = !p1_valid_reg || stage_adv;
    assign accept    = s_tvalid && s_tready;

    // request decode
    assign op      = opcode_t'(s_tuser);
    assign side_b  = (op == OP_B_SEND) || (op == OP_B_RECV);
    assign is_recv = (op == OP_A_RECV) || (op == OP_B_RECV);
    assign side_en = side_b ? cfg.b_fifo_en : cfg.a_fifo_en;

    assign push_ab   = accept && side_en && !side_b && !is_recv && !ab_st.full;
    assign push_ba   = accept && side_en &&  side_b && !is_recv && !ba_st.full;
    assign pop_ba    = accept && side_en && !side_b &&  is_recv && !ba_st.empty;
    assign pop_ab    = accept && side_en &&  side_b &&  is_recv && !ab_st.empty;
    assign set_err_a = accept && side_en && !side_b &&
                       (is_recv ? ba_st.empty : ab_st.full);
    assign set_err_b = accept && side_en &&  side_b &&
                       (is_recv ? ab_st.empty : ba_st.full);

    assign err_a_next = err_a_reg || set_err_a;
    assign err_b_next = err_b_reg || set_err_b;

    // stage one control, interrupts fire on first word in or last word out
    always_comb begin
        p1_next.pop_ok     = pop_ab || pop_ba;
        p1_next.pop_ab     = pop_ab;
        p1_next.err_a      = err_a_next;
        p1_next.err_b      = err_b_next;
        p1_next.irq_a_recv = push_ba && ba_st.empty  && cfg.a_recv_irq_en;
        p1_next.irq_b_recv = push_ab && ab_st.empty  && cfg.b_recv_irq_en;
        p1_next.irq_a_send = pop_ab  && ab_st.single && cfg.a_send_irq_en;
        p1_next.irq_b_send = pop_ba  && ba_st.single && cfg.b_send_irq_en;
    end

    // queues
    dcmf_queue #(.DEPTH(FIFO_DEPTH)) u_q_ab (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push_ab),
        .wdata   (s_tdata),
        .pop     (pop_ab),
        .rdata   (ab_rdata),
        .status  (ab_st)
    );

    dcmf_queue #(.DEPTH(FIFO_DEPTH)) u_q_ba (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push_ba),
        .wdata   (s_tdata),
        .pop     (pop_ba),
        .rdata   (ba_rdata),
        .status  (ba_st)
    );

    // sticky error flags and valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_a_reg    <= 1'b0;
            err_b_reg    <= 1'b0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            err_a_reg <= err_a_next;
            err_b_reg <= err_b_next;
            if (accept) begin
                p1_valid_reg <= 1'b1;
            end else if (stage_adv) begin
                p1_valid_reg <= 1'b0;
            end
            if (stage_adv) begin
                m_valid_reg <= p1_valid_reg;
            end
        end
    end

    // stage one payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_reg <= p1_next;
        end
    end

    // result register
    assign rd_word = !p1_reg.pop_ok ? '0 : (p1_reg.pop_ab ? ab_rdata : ba_rdata);

    always_ff @(posedge aclk) begin
        if (stage_adv && p1_valid_reg) begin
            m_data_reg <= {2'b00, p1_reg.irq_b_send, p1_reg.irq_b_recv,
                           p1_reg.irq_a_send, p1_reg.irq_a_recv,
                           p1_reg.err_b, p1_reg.err_a, rd_word};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // checks
    `ASSERT_NEXT(a_err_a_sticky, err_a_reg, err_a_reg, "side A error flag cleared")
    `ASSERT_NEXT(a_err_b_sticky, err_b_reg, err_b_reg, "side B error flag cleared")
    `ASSERT_ALWAYS(a_one_irq, !p1_valid_reg || $onehot0({p1_reg.irq_a_recv,
        p1_reg.irq_a_send, p1_reg.irq_b_recv, p1_reg.irq_b_send}),
        "more than one interrupt pulse for one request")
    `ASSERT_ALWAYS(a_one_queue_op, $countones({push_ab, push_ba, pop_ab, pop_ba}) <= 1,
        "one request touched two queues")

endmodule

// ----- verif/dual_cpu_mailbox_fifo_tb.sv -----
// ---------------------------------------------------------------------------
// dual_cpu_mailbox_fifo_tb
// Drives send and receive requests from both CPUs into the mailbox pair,
// keeps its own copy of both queues, the error flags and the register
// settings, and checks every result word field by field in order
// ---------------------------------------------------------------------------
module dual_cpu_mailbox_fifo_tb;

    import dcmf_pkg::*;

    localparam int unsigned FIFO_DEPTH = 16;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 150;
    localparam int unsigned DRAIN_CYCLES = 8;

    // one bus access from either CPU
    typedef struct {
        opcode_t     op;
        logic [31:0] data;
    } mbox_access_t;

    // result word, laid out as m_tdata from the top bit down
    typedef struct packed {
        logic [1:0]  pad;
        logic        irq_b_send;
        logic        irq_b_recv;
        logic        irq_a_send;
        logic        irq_a_recv;
        logic        b_error;
        logic        a_error;
        logic [31:0] read_data;
    } mbox_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [WORD_W-1:0]    s_tdata  = '0;   // [31:0] write_data
    opcode_t              s_tuser  = OP_A_SEND;  // [1:0] opcode
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;   // read_data, a_err, b_err, irqs a_recv..b_send, pad
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // stimulus and expectation stores
    mbox_access_t access_q[$];
    mbox_result_t result_due_q[$];

    // shadow of the block state
    logic [31:0] a_to_b_shadow[$];
    logic [31:0] b_to_a_shadow[$];
    logic        a_err_shadow = 1'b0;
    logic        b_err_shadow = 1'b0;
    cfg_t        cfg_shadow   = '0;

    // pacing controls shared with the sequence
    logic        send_idle_on = 1'b0;
    logic        recv_idle_on = 1'b0;
    logic        hold_start   = 1'b0;
    int unsigned send_gap     = 0;
    int unsigned recv_stall   = 0;
    int unsigned hold_left    = 0;

    int unsigned err_cnt    = 0;
    int unsigned result_cnt = 0;
    int unsigned cycle_cnt  = 0;

    dual_cpu_mailbox_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // one access applied to the shadow queues, returns the expected result word
    function automatic mbox_result_t mailbox_access(opcode_t op, logic [31:0] wdata);
        mbox_result_t r;
        r = '0;
        case (op)
            OP_A_SEND: begin
                if (cfg_shadow.a_fifo_en) begin
                    if (a_to_b_shadow.size() >= FIFO_DEPTH) begin
                        a_err_shadow = 1'b1;
                    end else begin
                        a_to_b_shadow.push_back(wdata);
                        if (a_to_b_shadow.size() == 1)
                            r.irq_b_recv = cfg_shadow.b_recv_irq_en;
                    end
                end
            end
            OP_B_SEND: begin
                if (cfg_shadow.b_fifo_en) begin
                    if (b_to_a_shadow.size() >= FIFO_DEPTH) begin
                        b_err_shadow = 1'b1;
                    end else begin
                        b_to_a_shadow.push_back(wdata);
                        if (b_to_a_shadow.size() == 1)
                            r.irq_a_recv = cfg_shadow.a_recv_irq_en;
                    end
                end
            end
            OP_A_RECV: begin
                if (cfg_shadow.a_fifo_en) begin
                    if (b_to_a_shadow.size() == 0) begin
                        a_err_shadow = 1'b1;
                    end else begin
                        r.read_data = b_to_a_shadow.pop_front();
                        if (b_to_a_shadow.size() == 0)
                            r.irq_b_send = cfg_shadow.b_send_irq_en;
                    end
                end
            end
            default: begin
                if (cfg_shadow.b_fifo_en) begin
                    if (a_to_b_shadow.size() == 0) begin
                        b_err_shadow = 1'b1;
                    end else begin
                        r.read_data = a_to_b_shadow.pop_front();
                        if (a_to_b_shadow.size() == 0)
                            r.irq_a_send = cfg_shadow.a_send_irq_en;
                    end
                end
            end
        endcase
        r.a_error = a_err_shadow;
        r.b_error = b_err_shadow;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result %0d: %s got %h want %h", result_cnt, what, got, want);
        err_cnt++;
    endtask

    task automatic add_access(opcode_t op, logic [31:0] data);
        mbox_access_t a;
        a.op   = op;
        a.data = data;
        access_q.push_back(a);
    endtask

    // register write: setup cycle, then access cycle
    task automatic write_reg(reg_idx_t idx, logic val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'b0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_A_FIFO_EN:     cfg_shadow.a_fifo_en     = val;
            REG_B_FIFO_EN:     cfg_shadow.b_fifo_en     = val;
            REG_A_RECV_IRQ_EN: cfg_shadow.a_recv_irq_en = val;
            REG_B_RECV_IRQ_EN: cfg_shadow.b_recv_irq_en = val;
            REG_A_SEND_IRQ_EN: cfg_shadow.a_send_irq_en = val;
            default:           cfg_shadow.b_send_irq_en = val;
        endcase
    endtask

    task automatic write_all_regs(logic [5:0] setting);
        for (int i = 0; i < 6; i++)
            write_reg(reg_idx_t'(i), setting[i]);
    endtask

    // wait until every request is in and every result is out
    task automatic wait_idle();
        @(negedge aclk);
        while (access_q.size() != 0 || s_tvalid || result_due_q.size() != 0)
            @(negedge aclk);
    endtask

    // random mix of sends and receives; send_pct biases toward filling or draining
    task automatic add_traffic(int unsigned n, int unsigned send_pct);
        logic        side_b;
        logic        is_send;
        logic [31:0] d;
        opcode_t     op;
        for (int unsigned i = 0; i < n; i++) begin
            side_b  = 1'($urandom_range(0, 1));
            is_send = $urandom_range(0, 99) < send_pct;
            if (side_b)
                op = is_send ? OP_B_SEND : OP_B_RECV;
            else
                op = is_send ? OP_A_SEND : OP_A_RECV;
            case ($urandom_range(0, 7))
                0:       d = '0;
                1:       d = '1;
                default: d = $urandom;
            endcase
            add_access(op, d);
        end
    endtask

    // request driver
    always @(posedge aclk) begin
        mbox_access_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                result_due_q.push_back(mailbox_access(s_tuser, s_tdata));
                send_gap = send_idle_on ? $urandom_range(0, 6) : 0;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (access_q.size() != 0) begin
                    nxt = access_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.op;
                    s_tdata  <= nxt.data;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver pacing
    always @(posedge aclk) begin
        mbox_result_t got;
        mbox_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (result_due_q.size() == 0) begin
                    report_mismatch("unexpected result", got.read_data, '0);
                end else begin
                    want = result_due_q.pop_front();
                    if (got.read_data !== want.read_data)
                        report_mismatch("read_data", got.read_data, want.read_data);
                    if (got.a_error !== want.a_error)
                        report_mismatch("side_a_error", got.a_error, want.a_error);
                    if (got.b_error !== want.b_error)
                        report_mismatch("side_b_error", got.b_error, want.b_error);
                    if (got.irq_a_recv !== want.irq_a_recv)
                        report_mismatch("irq_a_recv_fifo", got.irq_a_recv, want.irq_a_recv);
                    if (got.irq_a_send !== want.irq_a_send)
                        report_mismatch("irq_a_send_fifo", got.irq_a_send, want.irq_a_send);
                    if (got.irq_b_recv !== want.irq_b_recv)
                        report_mismatch("irq_b_recv_fifo", got.irq_b_recv, want.irq_b_recv);
                    if (got.irq_b_send !== want.irq_b_send)
                        report_mismatch("irq_b_send_fifo", got.irq_b_send, want.irq_b_send);
                end
                result_cnt++;
                recv_stall = recv_idle_on ? $urandom_range(0, 6) : 0;
            end
            // long hold-off is counted here so the sender keeps pushing meanwhile
            if (hold_start) begin
                hold_start = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // test sequence
    initial begin
        logic [5:0]  setting;
        int unsigned n_items;
        int unsigned send_pct;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // both sides disabled: accesses do nothing
        write_all_regs(6'b000000);
        @(negedge aclk);
        add_access(OP_A_SEND, 32'hFFFF_FFFF);
        add_access(OP_B_RECV, 32'hFFFF_FFFF);
        wait_idle();

        // everything on: each access kind, all four interrupt pulses, data extremes
        write_all_regs(6'b111111);
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        @(negedge aclk);
        add_access(OP_B_SEND, 32'h0000_0000);
        add_access(OP_A_RECV, 32'hFFFF_FFFF);
        add_access(OP_A_SEND, 32'hFFFF_FFFF);
        add_access(OP_B_RECV, 32'h0000_0000);
        // receives from empty queues raise both error flags
        add_access(OP_A_RECV, 32'h0);
        add_access(OP_B_RECV, 32'h0);
        // fill the A to B queue and push one more into the full queue
        for (int i = 0; i <= FIFO_DEPTH; i++)
            add_access(OP_A_SEND, $urandom);
        wait_idle();

        // random phases under several register settings
        for (int p = 0; p < 9; p++) begin
            n_items  = 62;
            send_pct = $urandom_range(25, 75);
            setting  = 6'($urandom);
            setting[0] = $urandom_range(0, 3) != 0;
            setting[1] = $urandom_range(0, 3) != 0;
            case (p)
                0: begin
                    setting  = 6'b111111;
                    send_pct = 20;
                end
                1: begin
                    setting  = 6'b111111;
                    send_pct = 80;
                end
                2: begin
                    setting = 6'b000000;
                    n_items = 30;
                end
                default: ;
            endcase
            write_all_regs(setting);
            send_idle_on = $urandom_range(0, 3) != 0;
            recv_idle_on = $urandom_range(0, 3) != 0;
            @(negedge aclk);
            // receiver holds off while the sender streams, backing up the input
            if (p == 3) begin
                send_idle_on = 1'b0;
                hold_start   = 1'b1;
            end
            add_traffic(n_items, send_pct);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (result_due_q.size() != 0)
            report_mismatch("results never arrived", result_due_q.size(), 0);
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/dcmf_pkg.sv
src/dcmf_ram.sv
src/dcmf_queue.sv
src/dcmf_cfg_regs.sv
src/dual_cpu_mailbox_fifo.sv
verif/dual_cpu_mailbox_fifo_tb.sv
